// ===== sv/object_ring_fifo_assert.svh =====
// ----------------------------------------------------------------------------
// object_ring_fifo_assert: assertion macros for the object ring FIFO
// Immediate-consequent and next-cycle-consequent property checks.
// ----------------------------------------------------------------------------
`ifndef OBJECT_RING_FIFO_ASSERT_SVH
`define OBJECT_RING_FIFO_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ORF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("orf: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define ORF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("orf: next-cycle check failed");

`endif

// ===== sv/orf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orf_pkg: shared types and constants for the object ring FIFO
// Operation codes, request/response payloads, FSM states and shifter control.
// ----------------------------------------------------------------------------
package orf_pkg;

   localparam int BYTE_W     = 8;
   localparam int DATA_W     = 64;
   localparam int DATA_BYTES = DATA_W / BYTE_W;
   localparam int INDEX_W    = 8;
   localparam int CSR_W      = 4;
   localparam int CNT_W      = 4;
   localparam int SLOT_W     = INDEX_W + CNT_W;

   localparam int DEPTH_DEFAULT            = 256;
   localparam int MAX_RECORD_BYTES_DEFAULT = 8;
   localparam logic [CSR_W-1:0] OBJECT_SIZE_RESET = CSR_W'(1);

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2,
      OP_DROP = 2'd3
   } orf_op_type;

   typedef struct packed {
      orf_op_type          operation;
      logic [DATA_W-1:0]   push_data;
      logic [INDEX_W-1:0]  record_index;
   } orf_req_type;

   typedef struct packed {
      logic                ok;
      logic [DATA_W-1:0]   read_data;
   } orf_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_DECIDE,
      ST_WRITE,
      ST_READ,
      ST_FLUSH,
      ST_CLEAR,
      ST_DONE
   } orf_state_type;

   typedef struct packed {
      logic load;   // take the push record into the shifter
      logic shift;  // move the shifter one byte toward bit 0
      logic fill;   // shift in the memory byte instead of zero
   } orf_shift_ctl_type;

endpackage

// ===== sv/orf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orf_ram: byte store of the ring
// Single address port, synchronous write, registered read.
// ----------------------------------------------------------------------------
module orf_ram #(
   parameter int DEPTH = orf_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic [$clog2(DEPTH)-1:0]    addr,
   input  logic [orf_pkg::BYTE_W-1:0]  wdata,
   output logic [orf_pkg::BYTE_W-1:0]  rdata
);
   import orf_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/orf_serdes.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orf_serdes: record shift register
// Streams a pushed record out byte by byte, low byte first, and packs
// read bytes back into a record word.
// ----------------------------------------------------------------------------
module orf_serdes (
   input  logic                                clock,
   input  orf_pkg::orf_shift_ctl_type          ctl,
   input  logic [orf_pkg::DATA_W-1:0]          push_data,
   input  logic [orf_pkg::BYTE_W-1:0]          rd_byte,
   output logic [orf_pkg::BYTE_W-1:0]          wr_byte,
   output logic [orf_pkg::DATA_W-1:0]          word
);
   import orf_pkg::*;

   logic [DATA_W-1:0] sr_ff;
   logic [DATA_W-1:0] sr_in;
   logic [BYTE_W-1:0] top_byte;

   always_comb begin
      top_byte = ctl.fill ? rd_byte : '0;
      sr_in    = sr_ff;
      if (ctl.load) begin
         sr_in = push_data;
      end else if (ctl.shift) begin
         sr_in = {top_byte, sr_ff[DATA_W-1:BYTE_W]};
      end
   end

   always_ff @(posedge clock) begin
      sr_ff <= sr_in;
   end

   assign wr_byte = sr_ff[BYTE_W-1:0];
   assign word    = sr_ff;

endmodule

// ===== sv/orf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orf_ctrl: sequencer of the object ring FIFO
// Holds head and tail, checks each operation, steps the byte store one slot
// per cycle and runs the clearing sweep after reset and drop.
// ----------------------------------------------------------------------------
module orf_ctrl #(
   parameter int DEPTH            = orf_pkg::DEPTH_DEFAULT,
   parameter int MAX_RECORD_BYTES = orf_pkg::MAX_RECORD_BYTES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  orf_pkg::orf_req_type                req_payload,
   input  logic [orf_pkg::CSR_W-1:0]           object_size,
   output orf_pkg::orf_shift_ctl_type          shift_ctl,
   input  logic [orf_pkg::BYTE_W-1:0]          wr_byte,
   input  logic [orf_pkg::DATA_W-1:0]          word,
   output logic                                mem_we,
   output logic [$clog2(DEPTH)-1:0]            mem_addr,
   output logic [orf_pkg::BYTE_W-1:0]          mem_wdata,
   output logic                                rsp_valid,
   output orf_pkg::orf_rsp_type                rsp_payload
);
   import orf_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = ((PW > SLOT_W) ? PW : SLOT_W) + 1;

   orf_state_type        state_ff, state_in;
   logic [PW-1:0]        head_ff, head_in;
   logic [PW-1:0]        tail_ff, tail_in;
   logic [PW-1:0]        addr_ff, addr_in;
   logic [PW-1:0]        addr_next;
   logic [PW-1:0]        held_ff, held_in;
   logic [PW:0]          held_calc;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [CNT_W-1:0]     n_clamp;
   logic [INDEX_W-1:0]   idx_ff, idx_in;
   orf_op_type           op_ff, op_in;
   logic                 ok_ff, ok_in;
   logic                 drop_ff, drop_in;
   logic                 cap_ff, cap_in;
   logic                 fill_ff, fill_in;
   logic                 wzero;
   logic                 push_ok, pop_ok, peek_ok;

   // record size, with zero taken as one and large sizes capped
   always_comb begin
      if (object_size == '0) begin
         n_clamp = CNT_W'(1);
      end else if (CNT_W'(object_size) > CNT_W'(MAX_RECORD_BYTES)) begin
         n_clamp = CNT_W'(MAX_RECORD_BYTES);
      end else begin
         n_clamp = CNT_W'(object_size);
      end
   end

   assign addr_next = (addr_ff == PW'(DEPTH - 1)) ? '0 : addr_ff + PW'(1);

   always_comb begin
      if (head_ff >= tail_ff) begin
         held_calc = {1'b0, head_ff} - {1'b0, tail_ff};
      end else begin
         held_calc = {1'b0, head_ff} + (PW+1)'(DEPTH) - {1'b0, tail_ff};
      end
   end

   // keep at least one byte free after a push
   assign push_ok = (CW'(held_ff) + CW'(n_ff)) < CW'(DEPTH);
   assign pop_ok  = CW'(held_ff) >= CW'(n_ff);
   assign peek_ok = !((CW'(slot_ff) > CW'(head_ff)) ||
                      (CW'(slot_ff) < CW'(tail_ff)) ||
                      (CW'(slot_ff) >= CW'(DEPTH)));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      addr_in         = addr_ff;
      held_in         = held_ff;
      slot_in         = slot_ff;
      cnt_in          = cnt_ff;
      n_in            = n_ff;
      idx_in          = idx_ff;
      op_in           = op_ff;
      ok_in           = ok_ff;
      drop_in         = drop_ff;
      cap_in          = 1'b0;
      fill_in         = 1'b0;
      busy            = 1'b1;
      rsp_valid       = 1'b0;
      mem_we          = 1'b0;
      wzero           = 1'b0;
      shift_ctl.load  = 1'b0;
      shift_ctl.shift = cap_ff;
      shift_ctl.fill  = fill_ff;

      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               shift_ctl.load = 1'b1;
               op_in          = req_payload.operation;
               idx_in         = req_payload.record_index;
               n_in           = n_clamp;
               ok_in          = 1'b0;
               if (req_payload.operation == OP_DROP) begin
                  head_in  = '0;
                  tail_in  = '0;
                  addr_in  = '0;
                  drop_in  = 1'b1;
                  ok_in    = 1'b1;
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            held_in  = held_calc[PW-1:0];
            slot_in  = SLOT_W'(idx_ff) * SLOT_W'(n_ff);
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cnt_in   = '0;
            state_in = ST_DONE;
            case (op_ff)
               OP_PUSH: begin
                  if (push_ok) begin
                     ok_in    = 1'b1;
                     addr_in  = head_ff;
                     state_in = ST_WRITE;
                  end
               end
               OP_POP: begin
                  if (pop_ok) begin
                     ok_in    = 1'b1;
                     addr_in  = tail_ff;
                     state_in = ST_READ;
                  end
               end
               OP_PEEK: begin
                  if (peek_ok) begin
                     ok_in    = 1'b1;
                     addr_in  = slot_ff[PW-1:0];
                     state_in = ST_READ;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_WRITE: begin
            mem_we          = 1'b1;
            shift_ctl.shift = 1'b1;
            addr_in         = addr_next;
            head_in         = addr_next;
            cnt_in          = cnt_ff + CNT_W'(1);
            if ((cnt_ff + CNT_W'(1)) == n_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            // walk all byte lanes so the record lands at bit 0
            cap_in = 1'b1;
            if (cnt_ff < n_ff) begin
               fill_in = 1'b1;
               addr_in = addr_next;
               if (op_ff == OP_POP) begin
                  tail_in = addr_next;
               end
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DATA_BYTES - 1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_DONE;
         end
         ST_CLEAR: begin
            mem_we  = 1'b1;
            wzero   = 1'b1;
            addr_in = addr_next;
            if (addr_ff == PW'(DEPTH - 1)) begin
               drop_in  = 1'b0;
               state_in = drop_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         addr_ff <= '0;
         cnt_ff  <= '0;
         drop_ff <= 1'b0;
         cap_ff  <= 1'b0;
         fill_ff <= 1'b0;
         ok_ff   <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         addr_ff <= addr_in;
         cnt_ff  <= cnt_in;
         drop_ff <= drop_in;
         cap_ff  <= cap_in;
         fill_ff <= fill_in;
         ok_ff   <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      slot_ff <= slot_in;
      n_ff    <= n_in;
      idx_ff  <= idx_in;
      op_ff   <= op_in;
   end

   assign mem_addr  = addr_ff;
   assign mem_wdata = wzero ? '0 : wr_byte;

   // only a successful pop or peek returns data
   assign rsp_payload.ok        = ok_ff;
   assign rsp_payload.read_data =
      (ok_ff && ((op_ff == OP_POP) || (op_ff == OP_PEEK))) ? word : '0;

endmodule

// ===== sv/object_ring_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// object_ring_fifo: byte ring holding fixed-size records
// Push, pop, peek by record number and drop over a DEPTH-byte circular store.
// ----------------------------------------------------------------------------
//  channel   | ports                         | transfer
//  ----------+-------------------------------+-------------------------------
//  request   | start, busy, req_payload      | edge with start high, busy low
//  response  | rsp_valid, rsp_payload        | edge ending the rsp_valid cycle
//  csr       | csr_wr_en, csr_wr_data        | edge with csr_wr_en high
//
//  Push runs calc, decide, one store write per record byte, then the response.
//  Pop and peek run calc, decide, then step all eight byte lanes of the record
//  shifter, one store slot per cycle on the single memory port, then flush.
//  A failed check answers from decide; busy drops the cycle after response.
//  Reset and drop sweep all DEPTH bytes of the store to zero, with busy high.
//  The response strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module object_ring_fifo #(
   parameter int DEPTH            = orf_pkg::DEPTH_DEFAULT,
   parameter int MAX_RECORD_BYTES = orf_pkg::MAX_RECORD_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  orf_pkg::orf_req_type          req_payload,
   output logic                          rsp_valid,
   output orf_pkg::orf_rsp_type          rsp_payload,
   input  logic                          csr_wr_en,
   input  logic [orf_pkg::CSR_W-1:0]     csr_wr_data
);
   import orf_pkg::*;

   `include "object_ring_fifo_assert.svh"

   logic [CSR_W-1:0]      object_size_ff;
   logic [CSR_W-1:0]      object_size_in;
   orf_shift_ctl_type     shift_ctl;
   logic [BYTE_W-1:0]     wr_byte;
   logic [BYTE_W-1:0]     rd_byte;
   logic [DATA_W-1:0]     word;
   logic                  mem_we;
   logic [$clog2(DEPTH)-1:0] mem_addr;
   logic [BYTE_W-1:0]     mem_wdata;

   assign object_size_in = csr_wr_en ? csr_wr_data : object_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         object_size_ff <= OBJECT_SIZE_RESET;
      end else begin
         object_size_ff <= object_size_in;
      end
   end

   orf_ctrl #(
      .DEPTH            (DEPTH),
      .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .object_size (object_size_ff),
      .shift_ctl   (shift_ctl),
      .wr_byte     (wr_byte),
      .word        (word),
      .mem_we      (mem_we),
      .mem_addr    (mem_addr),
      .mem_wdata   (mem_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   orf_serdes u_serdes (
      .clock     (clock),
      .ctl       (shift_ctl),
      .push_data (req_payload.push_data),
      .rd_byte   (rd_byte),
      .wr_byte   (wr_byte),
      .word      (word)
   );

   orf_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (rd_byte)
   );

   `ORF_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ORF_ASSERT_IMPL(a_fail_zero, clock, reset, rsp_valid && !rsp_payload.ok, rsp_payload.read_data == '0)
   `ORF_ASSERT_IMPL(a_write_busy, clock, reset, mem_we, busy)
   `ORF_ASSERT_NEXT(a_done_idle, clock, reset, rsp_valid, !rsp_valid && !busy)

endmodule
